[src/sfd_pkg.sv]
`default_nettype none
package sfd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IDLE_W  = 13;
  localparam int unsigned TMO_W   = 12;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 4;

  localparam logic [BYTE_W-1:0] SYNC1_BYTE  = 8'hFF;
  localparam logic [BYTE_W-1:0] SYNC2_BYTE  = 8'hFB;
  localparam logic [BYTE_W-1:0] ID_LIMIT    = 8'hF1;
  // 0xFF + 0xFB modulo 256, the header part of the checksum.
  localparam logic [BYTE_W-1:0] HDR_SUM     = 8'hFA;

  localparam logic [BYTE_W-1:0] MIN_LEN_RST = 8'd50;
  localparam logic [BYTE_W-1:0] MAX_LEN_RST = 8'd150;
  localparam logic [BYTE_W-1:0] ACC_ID_RST  = 8'd26;
  localparam logic [TMO_W-1:0]  TMO_RST     = 12'd1000;

  typedef enum logic [1:0] {
    REG_MIN_LEN = 2'd0,
    REG_MAX_LEN = 2'd1,
    REG_ACC_ID  = 2'd2,
    REG_TIMEOUT = 2'd3
  } reg_idx_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_SUM    = 2'd1,
    STAT_BAD_ID = 2'd2
  } frame_status_t;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  typedef enum logic [5:0] {
    PH_HUNT  = 6'b000001,
    PH_SYNC2 = 6'b000010,
    PH_ID    = 6'b000100,
    PH_LEN   = 6'b001000,
    PH_DATA  = 6'b010000,
    PH_SUM   = 6'b100000
  } phase_t;

endpackage
`default_nettype wire

[src/sfd_in_if.sv]
`default_nettype none
interface sfd_in_if
  import sfd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

[src/sfd_out_if.sv]
`default_nettype none
interface sfd_out_if
  import sfd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              result_kind;
  logic [BYTE_W-1:0] payload_byte;
  logic [BYTE_W-1:0] payload_index;
  logic [STAT_W-1:0] frame_status;
  logic [BYTE_W-1:0] frame_id;
  logic [BYTE_W-1:0] frame_length;
  logic [BYTE_W-1:0] computed_sum;
  logic [BYTE_W-1:0] received_sum;

  modport source (
    output valid, output result_kind, output payload_byte, output payload_index,
    output frame_status, output frame_id, output frame_length,
    output computed_sum, output received_sum, input ready
  );
  modport sink (
    input valid, input result_kind, input payload_byte, input payload_index,
    input frame_status, input frame_id, input frame_length,
    input computed_sum, input received_sum, output ready
  );
endinterface
`default_nettype wire

[src/sync_length_sum_frame_deframer_core.sv]
`default_nettype none
// Channel   Direction  Payload
// in_ch     sink       rx_byte: one received byte per request
// out_ch    source     payload byte result or end-of-frame report
// apb       slave      min_length, max_length, accepted_id, timeout_bytes at 0x0/0x4/0x8/0xC
//
// One byte is taken per cycle when not stalled; parser state advances in the cycle a byte is
// accepted and any result lands in the output register on the same edge.
// The single output register decouples the sides: a new byte is taken whenever
// that register is empty or its result is being taken in the same cycle.
// rst_n (synchronous) returns the parser to the hunt and the registers to defaults.
module sync_length_sum_frame_deframer_core
  import sfd_pkg::*;
#(
  // Receive buffer size: a length byte at or above it is not a length.
  parameter int unsigned BUF_SIZE = 256
)
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  sfd_in_if.sink                 in_ch,
  sfd_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam logic [BYTE_W:0] BUF_LIMIT = (BYTE_W+1)'(BUF_SIZE);

  logic [BYTE_W-1:0] min_len_r, max_len_r, acc_id_r;
  logic [TMO_W-1:0]  timeout_r;
  reg_idx_t          reg_sel;

  phase_t            phase_r, phase_nxt;
  logic [IDLE_W-1:0] idle_r, idle_nxt;
  logic [BYTE_W-1:0] remain_r, remain_nxt;
  logic [BYTE_W-1:0] pos_r, pos_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [BYTE_W-1:0] id_r, id_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;

  logic              out_valid_r;
  logic              kind_r, kind_nxt;
  logic [BYTE_W-1:0] pbyte_r, pbyte_nxt;
  logic [BYTE_W-1:0] pidx_r, pidx_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic [BYTE_W-1:0] fid_r, fid_nxt;
  logic [BYTE_W-1:0] flen_r, flen_nxt;
  logic [BYTE_W-1:0] csum_r, csum_nxt;
  logic [BYTE_W-1:0] rsum_r, rsum_nxt;
  logic              emit;

  logic              accept;
  logic [BYTE_W-1:0] b;
  logic [IDLE_W-1:0] idle_inc;
  logic              timed_out;
  phase_t            phase_eff;
  logic [BYTE_W-1:0] remain_dec;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RST;
      max_len_r <= MAX_LEN_RST;
      acc_id_r  <= ACC_ID_RST;
      timeout_r <= TMO_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_MIN_LEN: min_len_r <= pwdata[BYTE_W-1:0];
        REG_MAX_LEN: max_len_r <= pwdata[BYTE_W-1:0];
        REG_ACC_ID:  acc_id_r  <= pwdata[BYTE_W-1:0];
        REG_TIMEOUT: timeout_r <= pwdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MIN_LEN: prdata = {{(APB_DW-BYTE_W){1'b0}}, min_len_r};
      REG_MAX_LEN: prdata = {{(APB_DW-BYTE_W){1'b0}}, max_len_r};
      REG_ACC_ID:  prdata = {{(APB_DW-BYTE_W){1'b0}}, acc_id_r};
      REG_TIMEOUT: prdata = {{(APB_DW-TMO_W){1'b0}}, timeout_r};
      default:     prdata = '0;
    endcase
  end

  // Handshake
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;

  assign idle_inc   = idle_r + IDLE_W'(1);
  assign timed_out  = idle_inc > {1'b0, timeout_r};
  assign phase_eff  = timed_out ? PH_HUNT : phase_r;
  assign remain_dec = remain_r - BYTE_W'(1);

  always_comb begin
    phase_nxt  = phase_eff;
    idle_nxt   = timed_out ? '0 : idle_inc;
    remain_nxt = remain_r;
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    id_nxt     = id_r;
    len_nxt    = len_r;
    emit       = 1'b0;
    kind_nxt   = KIND_PAYLOAD;
    pbyte_nxt  = '0;
    pidx_nxt   = '0;
    stat_nxt   = STAT_OK;
    fid_nxt    = id_r;
    flen_nxt   = len_r;
    csum_nxt   = '0;
    rsum_nxt   = '0;

    if (phase_eff == PH_HUNT && b == SYNC1_BYTE) begin
      phase_nxt = PH_SYNC2;
      idle_nxt  = '0;
    end else if (phase_eff == PH_SYNC2 && b == SYNC2_BYTE) begin
      phase_nxt = PH_ID;
      idle_nxt  = '0;
    end else if (phase_eff == PH_SYNC2 && b == SYNC1_BYTE) begin
      idle_nxt = '0;
    end else if (phase_eff == PH_ID && b != '0 && b < ID_LIMIT) begin
      phase_nxt = PH_LEN;
      id_nxt    = b;
      idle_nxt  = '0;
    end else if (phase_eff == PH_LEN && {1'b0, b} < BUF_LIMIT) begin
      idle_nxt = '0;
      if (b < min_len_r || b > max_len_r) begin
        phase_nxt = PH_HUNT;
      end else begin
        phase_nxt  = PH_DATA;
        len_nxt    = b;
        remain_nxt = b;
        pos_nxt    = '0;
        sum_nxt    = HDR_SUM + id_r + b;
      end
    end else if (phase_eff == PH_DATA && remain_r != '0) begin
      remain_nxt = remain_dec;
      pos_nxt    = pos_r + BYTE_W'(1);
      sum_nxt    = sum_r + b;
      if (remain_dec == '0) begin
        phase_nxt = PH_SUM;
        idle_nxt  = '0;
      end
      emit      = 1'b1;
      pbyte_nxt = b;
      pidx_nxt  = pos_r;
    end else if (phase_eff == PH_SUM) begin
      phase_nxt = PH_HUNT;
      idle_nxt  = '0;
      emit      = 1'b1;
      kind_nxt  = KIND_REPORT;
      if (sum_r != b) begin
        stat_nxt = STAT_SUM;
      end else if (id_r != acc_id_r) begin
        stat_nxt = STAT_BAD_ID;
      end else begin
        stat_nxt = STAT_OK;
      end
      csum_nxt = sum_r;
      rsum_nxt = b;
    end else begin
      phase_nxt = (b == SYNC1_BYTE) ? PH_SYNC2 : PH_HUNT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      idle_r      <= '0;
      remain_r    <= '0;
      pos_r       <= '0;
      sum_r       <= '0;
      id_r        <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r  <= phase_nxt;
        idle_r   <= idle_nxt;
        remain_r <= remain_nxt;
        pos_r    <= pos_nxt;
        sum_r    <= sum_nxt;
        id_r     <= id_nxt;
        len_r    <= len_nxt;
      end
      if (accept && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      kind_r  <= kind_nxt;
      pbyte_r <= pbyte_nxt;
      pidx_r  <= pidx_nxt;
      stat_r  <= stat_nxt;
      fid_r   <= fid_nxt;
      flen_r  <= flen_nxt;
      csum_r  <= csum_nxt;
      rsum_r  <= rsum_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_kind   = kind_r;
  assign out_ch.payload_byte  = pbyte_r;
  assign out_ch.payload_index = pidx_r;
  assign out_ch.frame_status  = stat_r;
  assign out_ch.frame_id      = fid_r;
  assign out_ch.frame_length  = flen_r;
  assign out_ch.computed_sum  = csum_r;
  assign out_ch.received_sum  = rsum_r;

endmodule
`default_nettype wire
